FILE: rtl/first_fit_block_allocator_assert.svh
// Assertion macros for the first-fit block allocator checker.
// No dependencies; included by the checker file.
`ifndef FIRST_FIT_BLOCK_ALLOCATOR_ASSERT_SVH
`define FIRST_FIT_BLOCK_ALLOCATOR_ASSERT_SVH

// same-cycle implication
`define FFBA_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("ffba check failed");

// next-cycle implication
`define FFBA_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("ffba check failed");

`endif

FILE: rtl/ffba_pkg.sv
// Shared types and constants for the first-fit block allocator.
// No dependencies.
package ffba_pkg;

  localparam int OFF_W      = 24;
  localparam int CAP_W      = 24;
  localparam int REQ_W      = 25;
  localparam int ADDR_W     = 32;
  localparam int STAT_W     = 3;
  localparam int IN_DATA_W  = 64;
  localparam int OUT_DATA_W = 40;
  localparam int CFG_IDX_W  = 1;

  localparam int HEAP_MIN_BYTES   = 64;
  localparam int HEAP_RESET_BYTES = 1048576;

  localparam logic OP_ALLOC = 1'b0;
  localparam logic OP_FREE  = 1'b1;

  localparam logic [CFG_IDX_W-1:0] CFG_ENABLE = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_HEAP   = 1'b1;

  typedef enum logic [STAT_W-1:0] {
    ST_OK       = 3'd0,
    ST_DISABLED = 3'd1,
    ST_ZERO     = 3'd2,
    ST_NOFIT    = 3'd3,
    ST_NULL     = 3'd4,
    ST_UNKNOWN  = 3'd5
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_CHECK,
    S_SCAN,
    S_SPLIT,
    S_MARK,
    S_DONE
  } state_t;

  typedef struct packed {
    logic [OFF_W-1:0] off;
    logic [CAP_W-1:0] cap;
    logic             used;
  } entry_t;

  // controller -> datapath
  typedef struct packed {
    logic start;
    logic advance;
    logic hit;
    logic wr_split;
    logic wr_mark;
    logic load_out;
    logic load_ok;
  } dp_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic enabled;
    logic op_free;
    logic req_zero;
    logic addr_zero;
    logic fit;
    logic split_need;
    logic is_last;
    logic full;
    logic addr_match;
  } dp_stat_t;

endpackage

FILE: rtl/ffba_dp.sv
// Datapath: block table memory, scan index, request and result registers.
// Depends on ffba_pkg.
module ffba_dp #(
  parameter int          MAX_BLOCKS     = 64,
  parameter int          HEADER_BYTES   = 12,
  parameter logic [31:0] HEAP_BASE      = 32'hE400_0000,
  parameter int          HEAP_MAX_BYTES = 16777216
) (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  logic                                   cfg_we,
  input  logic [ffba_pkg::CFG_IDX_W-1:0]         cfg_index,
  input  logic [ffba_pkg::REQ_W-1:0]             cfg_wdata,
  input  logic                                   req_opcode,
  input  logic [ffba_pkg::REQ_W-1:0]             req_bytes,
  input  logic [ffba_pkg::ADDR_W-1:0]            req_free_address,
  input  ffba_pkg::dp_cmd_t                      cmd,
  output ffba_pkg::dp_stat_t                     stat,
  output logic [ffba_pkg::ADDR_W-1:0]            out_addr
);
  import ffba_pkg::*;

  localparam int IDX_W = (MAX_BLOCKS > 1) ? $clog2(MAX_BLOCKS) : 1;
  localparam int CNT_W = $clog2(MAX_BLOCKS + 1);
  localparam logic [REQ_W:0]   HDR_X   = (REQ_W+1)'(HEADER_BYTES);
  localparam logic [CAP_W-1:0] RST_CAP = CAP_W'(HEAP_RESET_BYTES - HEADER_BYTES);

  entry_t             mem [MAX_BLOCKS];
  entry_t             rd_word_r;
  logic               rd_dflt_r;
  logic               init0_r;
  logic [IDX_W-1:0]   idx_r, idx_nxt;
  logic [CNT_W-1:0]   count_r;
  logic               enabled_r;
  logic               op_r;
  logic [REQ_W-1:0]   req_r;
  logic [ADDR_W-1:0]  faddr_r;
  entry_t             mark_r, split_r;
  logic [ADDR_W-1:0]  res_addr_r;
  logic [ADDR_W-1:0]  out_addr_r;

  entry_t             cur;
  logic [ADDR_W-1:0]  payload;
  logic [REQ_W:0]     need_x;
  logic               do_split;
  logic [REQ_W-1:0]   heap_clamp;
  logic               rebuild;
  logic               we;
  logic [IDX_W-1:0]   wa;
  entry_t             wd;
  entry_t             split_word;
  logic [REQ_W:0]     new_off_x;
  logic [REQ_W:0]     new_cap_x;

  assign cur     = rd_dflt_r ? entry_t'{off: '0, cap: RST_CAP, used: 1'b0} : rd_word_r;
  assign payload = HEAP_BASE + ADDR_W'(cur.off) + ADDR_W'(HEADER_BYTES);
  assign need_x  = {1'b0, req_r} + HDR_X;

  assign stat.enabled    = enabled_r;
  assign stat.op_free    = (op_r == OP_FREE);
  assign stat.req_zero   = (req_r == '0);
  assign stat.addr_zero  = (faddr_r == '0);
  assign stat.fit        = !cur.used && ({1'b0, cur.cap} >= req_r);
  assign stat.split_need = ({2'b0, cur.cap} >= need_x);
  assign stat.is_last    = ((CNT_W'(idx_r) + CNT_W'(1)) == count_r);
  assign stat.full       = (count_r == CNT_W'(MAX_BLOCKS));
  assign stat.addr_match = (payload == faddr_r);

  assign do_split  = (op_r == OP_ALLOC) && stat.split_need && stat.is_last;
  assign new_off_x = {2'b0, cur.off} + {1'b0, req_r} + HDR_X;
  assign new_cap_x = {2'b0, cur.cap} - need_x;

  always_comb begin
    split_word.off  = new_off_x[OFF_W-1:0];
    split_word.cap  = new_cap_x[CAP_W-1:0];
    split_word.used = 1'b0;
  end

  // heap size clamp for a rebuild
  always_comb begin
    heap_clamp = cfg_wdata;
    if (cfg_wdata < REQ_W'(HEAP_MIN_BYTES)) begin
      heap_clamp = REQ_W'(HEAP_MIN_BYTES);
    end else if (cfg_wdata > REQ_W'(HEAP_MAX_BYTES)) begin
      heap_clamp = REQ_W'(HEAP_MAX_BYTES);
    end
  end

  assign rebuild = cfg_we && (cfg_index == CFG_HEAP);

  // single write port: rebuild, split entry, or marked entry
  always_comb begin
    we = 1'b0;
    wa = idx_r;
    wd = mark_r;
    if (rebuild) begin
      we = 1'b1;
      wa = '0;
      wd = '{off: '0, cap: CAP_W'(heap_clamp - REQ_W'(HEADER_BYTES)), used: 1'b0};
    end else if (cmd.wr_split) begin
      we = 1'b1;
      wa = idx_r + IDX_W'(1);
      wd = split_r;
    end else if (cmd.wr_mark) begin
      we = 1'b1;
    end
  end

  always_comb begin
    idx_nxt = idx_r;
    if (cmd.start) begin
      idx_nxt = '0;
    end else if (cmd.advance) begin
      idx_nxt = idx_r + IDX_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mem[wa] <= wd;
    end
    rd_word_r <= mem[idx_nxt];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      init0_r   <= 1'b1;
      rd_dflt_r <= 1'b1;
      idx_r     <= '0;
      count_r   <= CNT_W'(1);
      enabled_r <= 1'b0;
    end else begin
      rd_dflt_r <= init0_r && (idx_nxt == '0);
      if (we && (wa == '0)) begin
        init0_r <= 1'b0;
      end
      idx_r <= idx_nxt;
      if (rebuild) begin
        count_r <= CNT_W'(1);
      end else if (cmd.wr_split) begin
        count_r <= count_r + CNT_W'(1);
      end
      if (cfg_we && (cfg_index == CFG_ENABLE)) begin
        enabled_r <= cfg_wdata[0];
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (cmd.start) begin
      op_r    <= req_opcode;
      req_r   <= req_bytes;
      faddr_r <= req_free_address;
    end
    if (cmd.hit) begin
      mark_r.off  <= cur.off;
      mark_r.cap  <= do_split ? req_r[CAP_W-1:0] : cur.cap;
      mark_r.used <= (op_r == OP_ALLOC);
      split_r     <= split_word;
      res_addr_r  <= payload;
    end
    if (cmd.load_out) begin
      out_addr_r <= cmd.load_ok ? res_addr_r : '0;
    end
  end

  assign out_addr = out_addr_r;

endmodule

FILE: rtl/ffba_ctrl.sv
// Controller state machine: request decode, table scan sequencing, result handoff.
// Depends on ffba_pkg.
module ffba_ctrl (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic                       cfg_we,
  output logic                       out_valid,
  input  logic                       out_ready,
  output ffba_pkg::status_t          out_status,
  input  ffba_pkg::dp_stat_t         stat,
  output ffba_pkg::dp_cmd_t          cmd
);
  import ffba_pkg::*;

  state_t  state_r, state_nxt;
  status_t res_r, res_nxt;
  status_t out_status_r;
  logic    out_valid_r;

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (in_valid && !cfg_we) state_nxt = S_CHECK;
      end
      S_CHECK: begin
        if (!stat.enabled) begin
          state_nxt = S_DONE;
        end else if (!stat.op_free && stat.req_zero) begin
          state_nxt = S_DONE;
        end else if (stat.op_free && stat.addr_zero) begin
          state_nxt = S_DONE;
        end else begin
          state_nxt = S_SCAN;
        end
      end
      S_SCAN: begin
        if (!stat.op_free) begin
          if (stat.fit) begin
            if (stat.split_need && stat.is_last) begin
              state_nxt = stat.full ? S_DONE : S_SPLIT;
            end else begin
              state_nxt = S_MARK;
            end
          end else if (stat.is_last) begin
            state_nxt = S_DONE;
          end
        end else begin
          if (stat.addr_match) begin
            state_nxt = S_MARK;
          end else if (stat.is_last) begin
            state_nxt = S_DONE;
          end
        end
      end
      S_SPLIT: state_nxt = S_MARK;
      S_MARK:  state_nxt = S_DONE;
      S_DONE: begin
        if (!out_valid_r || out_ready) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // outputs and commands
  always_comb begin
    cmd      = '0;
    in_ready = 1'b0;
    res_nxt  = res_r;
    case (state_r)
      S_IDLE: begin
        in_ready  = !cfg_we;
        cmd.start = in_valid && !cfg_we;
      end
      S_CHECK: begin
        if (!stat.enabled) begin
          res_nxt = ST_DISABLED;
        end else if (!stat.op_free && stat.req_zero) begin
          res_nxt = ST_ZERO;
        end else if (stat.op_free && stat.addr_zero) begin
          res_nxt = ST_NULL;
        end
      end
      S_SCAN: begin
        if (!stat.op_free) begin
          if (stat.fit) begin
            if (stat.split_need && stat.is_last && stat.full) begin
              res_nxt = ST_NOFIT;
            end else begin
              res_nxt = ST_OK;
              cmd.hit = 1'b1;
            end
          end else if (stat.is_last) begin
            res_nxt = ST_NOFIT;
          end else begin
            cmd.advance = 1'b1;
          end
        end else begin
          if (stat.addr_match) begin
            res_nxt = ST_OK;
            cmd.hit = 1'b1;
          end else if (stat.is_last) begin
            res_nxt = ST_UNKNOWN;
          end else begin
            cmd.advance = 1'b1;
          end
        end
      end
      S_SPLIT: cmd.wr_split = 1'b1;
      S_MARK:  cmd.wr_mark = 1'b1;
      S_DONE: begin
        cmd.load_out = !out_valid_r || out_ready;
        cmd.load_ok  = (res_r == ST_OK);
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      res_r       <= ST_OK;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      res_r   <= res_nxt;
      if (cmd.load_out) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) out_status_r <= res_r;
  end

  assign out_valid  = out_valid_r;
  assign out_status = out_status_r;

endmodule

FILE: rtl/first_fit_block_allocator.sv
// First-fit block allocator top level: stream ports, controller and datapath.
// Depends on ffba_pkg, ffba_ctrl, ffba_dp.
//
// Usage:
//   in_ beats carry one request: in_tuser is the opcode (0 allocate, 1 free),
//   in_tdata holds request_bytes and free_address. Each request answers with
//   exactly one out_ beat: status and payload_address (zero on any failure).
//   cfg_we writes register cfg_index: 0 heap_enabled, 1 heap_bytes (clamped
//   to 64..HEAP_MAX_BYTES, which rebuilds the table as one free block).
//   Write configuration only while no request is in flight; in_tready drops
//   during a cfg_we cycle.
// Timing:
//   One request at a time. A request walks the table one entry per cycle
//   through the table memory, stopping at the first fit (a matching block
//   for a free) or the last entry. A refused request goes from the check to
//   the done state; a hit passes the split state (when a block is split) and
//   the mark state first; a failed scan or a full table goes straight to
//   done. in_tready returns the cycle after the result is loaded.
// Reset: synchronous, active low; heap disabled, one free block of
//   1048576 - HEADER_BYTES bytes. No clearing pass is needed.
// Stall: the result sits in an output register; a stalled receiver holds
//   the block in its final state until that register frees up.
module first_fit_block_allocator #(
  parameter int          MAX_BLOCKS     = 64,
  parameter int          HEADER_BYTES   = 12,
  parameter logic [31:0] HEAP_BASE      = 32'hE400_0000,
  parameter int          HEAP_MAX_BYTES = 16777216
) (
  input  logic                                clk,
  input  logic                                rst_n,
  // config write port
  input  logic                                cfg_we,
  input  logic [ffba_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [ffba_pkg::REQ_W-1:0]          cfg_wdata,
  // request stream
  input  logic                                in_tvalid,
  output logic                                in_tready,
  input  logic [ffba_pkg::IN_DATA_W-1:0]      in_tdata,   // [24:0] request_bytes, [56:25] free_address
  input  logic                                in_tuser,   // [0] opcode
  // result stream
  output logic                                out_tvalid,
  input  logic                                out_tready,
  output logic [ffba_pkg::OUT_DATA_W-1:0]     out_tdata   // [2:0] status, [34:3] payload_address
);
  import ffba_pkg::*;

  dp_cmd_t            cmd;
  dp_stat_t           stat;
  status_t            out_status;
  logic [ADDR_W-1:0]  out_addr;

  // unused in_tdata pad bits [63:57] are dropped
  ffba_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_tvalid),
    .in_ready   (in_tready),
    .cfg_we     (cfg_we),
    .out_valid  (out_tvalid),
    .out_ready  (out_tready),
    .out_status (out_status),
    .stat       (stat),
    .cmd        (cmd)
  );

  ffba_dp #(
    .MAX_BLOCKS     (MAX_BLOCKS),
    .HEADER_BYTES   (HEADER_BYTES),
    .HEAP_BASE      (HEAP_BASE),
    .HEAP_MAX_BYTES (HEAP_MAX_BYTES)
  ) u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_we           (cfg_we),
    .cfg_index        (cfg_index),
    .cfg_wdata        (cfg_wdata),
    .req_opcode       (in_tuser),
    .req_bytes        (in_tdata[REQ_W-1:0]),
    .req_free_address (in_tdata[REQ_W+ADDR_W-1:REQ_W]),
    .cmd              (cmd),
    .stat             (stat),
    .out_addr         (out_addr)
  );

  // pack result beat, zero fill to whole bytes
  assign out_tdata = {(OUT_DATA_W-ADDR_W-STAT_W)'(0), out_addr, out_status};

endmodule

FILE: rtl/ffba_checker.sv
// Port-level checker for the first-fit block allocator, bound to the top level.
// Depends on ffba_pkg and first_fit_block_allocator_assert.svh.
`include "first_fit_block_allocator_assert.svh"

module ffba_checker (
  input logic                                clk,
  input logic                                rst_n,
  input logic                                cfg_we,
  input logic                                in_tvalid,
  input logic                                in_tready,
  input logic                                out_tvalid,
  input logic                                out_tready,
  input logic [ffba_pkg::OUT_DATA_W-1:0]     out_tdata
);
  import ffba_pkg::*;

  logic fail_beat;
  logic bad_code;

  assign fail_beat = out_tvalid && (out_tdata[STAT_W-1:0] != ST_OK);
  assign bad_code  = (out_tdata[STAT_W-1:0] == 3'd6) || (out_tdata[STAT_W-1:0] == 3'd7);

  // held result beat keeps its data
  `FFBA_ASSERT_NXT(a_out_hold, clk, rst_n, out_tvalid && !out_tready, out_tvalid && $stable(out_tdata))
  // any refusal reports a zero address, and codes stay in range
  `FFBA_ASSERT_NOW(a_fail_zero, clk, rst_n, fail_beat, out_tdata[STAT_W+ADDR_W-1:STAT_W] == '0)
  `FFBA_ASSERT_NOW(a_code_range, clk, rst_n, out_tvalid, !bad_code)
  // one request in flight: no accept right after an accept, none during config
  `FFBA_ASSERT_NXT(a_one_inflight, clk, rst_n, in_tvalid && in_tready, !in_tready)
  `FFBA_ASSERT_NOW(a_cfg_block, clk, rst_n, cfg_we, !in_tready)

endmodule

bind first_fit_block_allocator ffba_checker u_ffba_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .cfg_we     (cfg_we),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);
